FILE: design/rbpm_pkg.sv
// ----------------------------------------------------------------------------
// rbpm_pkg
// Shared types and codes for the binary prefix rule match block.
// ----------------------------------------------------------------------------
package rbpm_pkg;

  // action field codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic start;   // item taken: capture key, clear scan state
    logic issue;   // read the next rule entry
    logic finish;  // load the result register, commit an insert
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic at_end;       // every stored entry has been read
    logic rd_pending;   // a read has returned, its entry is compared now
    logic cmp_hit;      // the entry just read matches (or duplicates)
    logic out_busy;     // result register full and not being taken
  } dp_stat_t;

endpackage

FILE: design/rbpm_chan_if.sv
// ----------------------------------------------------------------------------
// rbpm channel interfaces
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface rbpm_in_if #(
  parameter int KW = 32,
  parameter int LW = 6
);
  logic          valid;
  logic          ready;
  logic          action;
  logic [KW-1:0] key_bits;
  logic [LW-1:0] key_length;
  logic          wildcard_req;

  modport source (output valid, action, key_bits, key_length, wildcard_req,
                  input ready);
  modport sink   (input valid, action, key_bits, key_length, wildcard_req,
                  output ready);
endinterface

interface rbpm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic table_full;

  modport source (output valid, matched, table_full, input ready);
  modport sink   (input valid, matched, table_full, output ready);
endinterface

FILE: design/rbpm_ram.sv
// ----------------------------------------------------------------------------
// rbpm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rbpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/rbpm_ctrl.sv
// ----------------------------------------------------------------------------
// rbpm_ctrl
// Sequencer: take an item, scan the stored rules, post the result.
// ----------------------------------------------------------------------------
module rbpm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rbpm_pkg::dp_stat_t   stat,
  output rbpm_pkg::ctrl_cmd_t  cmd
);

  import rbpm_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.issue = !stat.at_end;
        // stop early on a hit; otherwise once the last read is compared
        if (stat.cmp_hit || (stat.at_end && !stat.rd_pending)) begin
          cmd.issue = 1'b0;
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: design/rbpm_dp.sv
// ----------------------------------------------------------------------------
// rbpm_dp
// Key capture, rule RAM, entry compare, fill count and result register.
// ----------------------------------------------------------------------------
module rbpm_dp #(
  parameter int KEY_BITS     = 32,
  parameter int RULE_ENTRIES = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_action,
  input  logic [KEY_BITS-1:0]              in_key_bits,
  input  logic [$clog2(KEY_BITS+1)-1:0]    in_key_length,
  input  logic                             in_wildcard_req,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_matched,
  output logic                             out_table_full,
  input  rbpm_pkg::ctrl_cmd_t              cmd,
  output rbpm_pkg::dp_stat_t               stat
);

  import rbpm_pkg::*;

  localparam int KW = KEY_BITS;
  localparam int LW = $clog2(KEY_BITS + 1);
  localparam int AW = $clog2(RULE_ENTRIES);
  localparam int CW = $clog2(RULE_ENTRIES + 1);
  localparam int RW = KW + LW + 1;

  // keep the top len bits of a key
  function automatic logic [KW-1:0] lead_mask(input logic [LW-1:0] len);
    return ~({KW{1'b1}} >> len);
  endfunction

  logic          action_r;
  logic          wild_r;
  logic [KW-1:0] key_r;
  logic [LW-1:0] len_r;
  logic [CW-1:0] idx_r;
  logic [CW-1:0] count_r;
  logic          rdv_r;
  logic          hit_r;
  logic          out_valid_r;
  logic          matched_r;
  logic          full_r;

  logic [LW-1:0] sat_len;
  logic [RW-1:0] rd_data;
  logic [KW-1:0] r_bits;
  logic [LW-1:0] r_len;
  logic          r_pfx;
  logic          search_hit;
  logic          dup_hit;
  logic          tbl_full;
  logic          wr_en;

  assign sat_len = (in_key_length > LW'(KW)) ? LW'(KW) : in_key_length;

  // payload capture
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      action_r <= in_action;
      wild_r   <= in_wildcard_req;
      len_r    <= sat_len;
      key_r    <= in_key_bits & lead_mask(sat_len);
    end
  end

  // rule store: {prefix flag, length, bits}
  assign tbl_full = (count_r == CW'(RULE_ENTRIES));
  assign wr_en    = cmd.finish && (action_r == ACT_INSERT) && !hit_r && !tbl_full;

  rbpm_ram #(
    .WIDTH (RW),
    .DEPTH (RULE_ENTRIES)
  ) u_rule_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count_r[AW-1:0]),
    .wdata ({wild_r, len_r, key_r}),
    .re    (cmd.issue),
    .raddr (idx_r[AW-1:0]),
    .rdata (rd_data)
  );

  assign r_bits = rd_data[KW-1:0];
  assign r_len  = rd_data[KW+LW-1:KW];
  assign r_pfx  = rd_data[RW-1];

  always_comb begin
    if (r_pfx) begin
      search_hit = (r_len <= len_r) && ((key_r & lead_mask(r_len)) == r_bits);
    end else begin
      search_hit = (r_len == len_r) && (r_bits == key_r);
    end
  end

  assign dup_hit = (r_pfx == wild_r) && (r_len == len_r) && (r_bits == key_r);

  assign stat.at_end     = (idx_r == count_r);
  assign stat.rd_pending = rdv_r;
  assign stat.cmp_hit    = rdv_r && ((action_r == ACT_SEARCH) ? search_hit : dup_hit);
  assign stat.out_busy   = out_valid_r && !out_ready;

  // scan control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      rdv_r   <= 1'b0;
      hit_r   <= 1'b0;
      count_r <= '0;
    end else begin
      rdv_r <= cmd.issue;
      if (cmd.start) begin
        idx_r <= '0;
        hit_r <= 1'b0;
      end else begin
        if (cmd.issue) begin
          idx_r <= idx_r + CW'(1);
        end
        if (stat.cmp_hit) begin
          hit_r <= 1'b1;
        end
      end
      if (wr_en) begin
        count_r <= count_r + CW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      matched_r <= (action_r == ACT_SEARCH) && hit_r;
      full_r    <= (action_r == ACT_INSERT) && !hit_r && tbl_full;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_matched    = matched_r;
  assign out_table_full = full_r;

endmodule

FILE: design/binary_prefix_rule_match_top.sv
// ----------------------------------------------------------------------------
// binary_prefix_rule_match_top - binary prefix rule table
// Scan: stored rules are read in order; a hit (match or duplicate) ends
//   the scan early.
// Throughput: one item in flight; the next item can be taken once the
//   result is loaded, and a held result stalls the following item's finish.
// Reset (rst_n low, synchronous): table empty, no result pending.
// ----------------------------------------------------------------------------
//
// Rules are held in a single RAM of RULE_ENTRIES words {wildcard, length,
// bits}. Entries fill in order and are never removed, so the fill count
// alone marks which entries are live; the RAM itself needs no clearing.
//
// Insert: every live rule is scanned for a duplicate (same kind, length and
// bits). A duplicate commits nothing and reports table_full = 0. Otherwise
// the rule goes to entry [count] if there is room, else table_full = 1.
//
// Search: an exact rule hits on equal length and bits; a wildcard rule of
// length L hits when L <= query length and the first L bits agree.
//
// Lengths above KEY_BITS saturate; key bits past the length are cleared
// before they are stored or compared.
//
// The result register parts the two sides: a posted result may wait on
// out_ch.ready while the controller is back in idle taking the next item.
// ----------------------------------------------------------------------------
module binary_prefix_rule_match_top #(
  parameter int KEY_BITS     = 32,
  parameter int RULE_ENTRIES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  rbpm_in_if.sink    in_ch,
  rbpm_out_if.source out_ch
);

  import rbpm_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      in_ready;

  // sequencer
  rbpm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  assign in_ch.ready = in_ready;

  // rule store, compare and result register
  rbpm_dp #(
    .KEY_BITS     (KEY_BITS),
    .RULE_ENTRIES (RULE_ENTRIES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_action       (in_ch.action),
    .in_key_bits     (in_ch.key_bits),
    .in_key_length   (in_ch.key_length),
    .in_wildcard_req (in_ch.wildcard_req),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_matched     (out_ch.matched),
    .out_table_full  (out_ch.table_full),
    .cmd             (cmd),
    .stat            (stat)
  );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - binary prefix rule match
// Feeds insert and search items through the request channel and checks every
// result against an in-bench model of the rule table. Both channel sides idle
// at random, and the sender drains the block before selected items.
// ----------------------------------------------------------------------------
module testbench;
  import rbpm_pkg::*;

  localparam int KW          = 32;
  localparam int RULES       = 64;
  localparam int N_RANDOM    = 1680;
  localparam int TAIL_ITEMS  = 120;    // items after the catch-all rule
  localparam int STALL_LIMIT = 3000;   // cycles with no handshake at all
  localparam int SETTLE      = 80;     // longer than the worst latency

  typedef struct {
    logic          action;
    logic [KW-1:0] key_bits;
    logic [5:0]    key_length;
    logic          wildcard_req;
    bit            drain;      // hold this item until all results are back
  } request_t;

  typedef struct packed {
    logic matched;
    logic table_full;
  } verdict_t;

  // normalized rule, as the generator tracks what the block should hold
  typedef struct {
    logic [KW-1:0] bits;
    int            len;
    logic          wild;
  } rule_t;

  logic clk;
  logic rst_n;

  rbpm_in_if #(.KW(KW), .LW(6)) in_ch();
  rbpm_out_if                   out_ch();

  binary_prefix_rule_match_top #(
    .KEY_BITS    (KW),
    .RULE_ENTRIES(RULES)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  request_t req_q[$];       // items waiting for the driver
  verdict_t verdict_q[$];   // predicted results, oldest first
  rule_t    planned[$];     // rules the generator expects to be stored

  // rule table model
  logic [KW-1:0] held_bits [RULES];
  int            held_len  [RULES];
  logic          held_wild [RULES];
  int            rules_held = 0;

  int  n_taken   = 0;
  int  n_seen    = 0;
  int  n_total   = 0;
  int  n_errors  = 0;
  int  idle_cnt  = 0;
  bit  in_acc    = 1'b0;

  // ---------------------------------------------------------------------------
  // helpers shared by the model and the generator
  // ---------------------------------------------------------------------------

  // keeps the top len bits of a key; len 0 gives an all-zero mask
  function automatic logic [KW-1:0] top_mask(int len);
    logic [KW-1:0] m;
    m = '1;
    return m << (KW - len);
  endfunction

  function automatic int sat_len(logic [5:0] l);
    return (l > KW) ? KW : int'(l);
  endfunction

  function automatic bit planned_has(logic [KW-1:0] bits, int len, logic wild);
    foreach (planned[i])
      if (planned[i].bits == bits && planned[i].len == len && planned[i].wild == wild)
        return 1'b1;
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // model: one accepted item in, one verdict out, table updated on insert
  // ---------------------------------------------------------------------------
  function automatic verdict_t predict_verdict(request_t r);
    verdict_t      v;
    int            len;
    logic [KW-1:0] key;
    bit            dup;
    v   = '0;
    len = sat_len(r.key_length);
    key = r.key_bits & top_mask(len);   // bits past the length never count
    dup = 1'b0;
    if (r.action == ACT_SEARCH) begin
      for (int i = 0; i < rules_held; i++) begin
        if (held_wild[i]) begin
          // prefix rule: no longer than the query, leading bits agree
          if (held_len[i] <= len && (key & top_mask(held_len[i])) == held_bits[i])
            v.matched = 1'b1;
        end else if (held_len[i] == len && key == held_bits[i]) begin
          v.matched = 1'b1;
        end
      end
    end else begin
      for (int i = 0; i < rules_held; i++)
        if (held_wild[i] == r.wildcard_req && held_len[i] == len && held_bits[i] == key)
          dup = 1'b1;
      // a duplicate is silently absorbed, even into a full table
      if (!dup) begin
        if (rules_held >= RULES) begin
          v.table_full = 1'b1;
        end else begin
          held_bits[rules_held] = key;
          held_len[rules_held]  = len;
          held_wild[rules_held] = r.wildcard_req;
          rules_held++;
        end
      end
    end
    return v;
  endfunction

  // queue one item; inserts also update the generator's view of the table
  task automatic add_req(logic act, logic [KW-1:0] bits, logic [5:0] len,
                         logic wild, bit drain = 1'b0);
    request_t r;
    rule_t    n;
    r.action       = act;
    r.key_bits     = bits;
    r.key_length   = len;
    r.wildcard_req = wild;
    r.drain        = drain;
    req_q = {req_q, r};
    if (act == ACT_INSERT) begin
      n.len  = sat_len(len);
      n.bits = bits & top_mask(n.len);
      n.wild = wild;
      if (!planned_has(n.bits, n.len, n.wild) && planned.size() < RULES)
        planned = {planned, n};
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    rule_t         p;
    int            pick;
    int            qlen;
    logic [KW-1:0] m;
    logic [KW-1:0] bits;
    logic          wild;
    bit            allow_new;

    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.action       = ACT_INSERT;
    in_ch.key_bits     = '0;
    in_ch.key_length   = '0;
    in_ch.wildcard_req = 1'b0;
    out_ch.ready       = 1'b0;

    // directed: empty table, exact vs prefix, saturation, junk tail bits,
    // duplicates, and the wildcard flag being ignored on a search
    add_req(ACT_SEARCH, 32'hFFFF_FFFF, 6'd32, 1'b1);  // nothing stored yet
    add_req(ACT_INSERT, 32'hFFFF_FFFF, 6'd32, 1'b0);  // full-width exact
    add_req(ACT_SEARCH, 32'hFFFF_FFFF, 6'd32, 1'b0);
    add_req(ACT_SEARCH, 32'hFFFF_FFFF, 6'd31, 1'b0);  // exact needs equal length
    add_req(ACT_INSERT, 32'hDEAD_BEEF, 6'd0,  1'b0);  // zero-length exact
    add_req(ACT_SEARCH, 32'h1234_5678, 6'd0,  1'b0);
    add_req(ACT_INSERT, 32'hA512_3456, 6'd8,  1'b1);  // prefix, junk past 8
    add_req(ACT_SEARCH, 32'hA5FF_FFFF, 6'd32, 1'b0);
    add_req(ACT_SEARCH, 32'hA500_0000, 6'd7,  1'b0);  // query shorter than rule
    add_req(ACT_SEARCH, 32'hA500_0000, 6'd8,  1'b0);
    add_req(ACT_INSERT, 32'hA599_9999, 6'd8,  1'b1);  // duplicate prefix
    add_req(ACT_INSERT, 32'hA500_0000, 6'd8,  1'b0);  // same bits, other kind
    add_req(ACT_SEARCH, 32'hA5FF_0000, 6'd8,  1'b1);
    add_req(ACT_INSERT, 32'h0000_0001, 6'd63, 1'b0);  // length saturates
    add_req(ACT_SEARCH, 32'h0000_0001, 6'd40, 1'b0);
    add_req(ACT_SEARCH, 32'h0000_0001, 6'd32, 1'b1);
    add_req(ACT_INSERT, 32'h8000_0000, 6'd32, 1'b1);  // full-width prefix
    add_req(ACT_SEARCH, 32'h8000_0000, 6'd63, 1'b1);
    add_req(ACT_SEARCH, 32'h7000_0000, 6'd16, 1'b1);
    add_req(ACT_INSERT, 32'h0000_0000, 6'd32, 1'b0);
    add_req(ACT_SEARCH, 32'h0000_0000, 6'd32, 1'b0);
    add_req(ACT_INSERT, 32'h0000_0000, 6'd33, 1'b0);  // duplicate after saturation

    // random: mostly searches built from stored rules. New rules stop one
    // short of a full table so the catch-all prefix can take the last slot;
    // after that every new insert is dropped and every search hits.
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - TAIL_ITEMS)
        add_req(ACT_INSERT, $urandom(), 6'd0, 1'b1, 1'b1);
      allow_new = (i >= N_RANDOM - TAIL_ITEMS) || (planned.size() < RULES - 1);
      pick      = $urandom_range(99);
      if (pick < 18) begin
        if (!allow_new || $urandom_range(99) < 15) begin
          // duplicate with fresh junk past the length
          p = planned[$urandom_range(planned.size() - 1)];
          qlen = (p.len == KW && $urandom_range(1)) ? $urandom_range(KW, 63) : p.len;
          add_req(ACT_INSERT, p.bits | ($urandom() & ~top_mask(p.len)), qlen[5:0], p.wild,
                  (i == 200) || (i == 900));
        end else begin
          wild = 1'($urandom_range(1));
          if (wild)
            qlen = $urandom_range(6, KW);
          else if ($urandom_range(9) == 0)
            qlen = $urandom_range(KW + 1, 63);
          else
            qlen = $urandom_range(1, KW);
          add_req(ACT_INSERT, $urandom(), qlen[5:0], wild, (i == 200) || (i == 900));
        end
      end else if (pick < 75 && planned.size() > 0) begin
        // query aimed at a stored rule, sometimes just off it
        p = planned[$urandom_range(planned.size() - 1)];
        if (p.wild) begin
          qlen = $urandom_range(p.len, 63);
          if (p.len > 0 && $urandom_range(9) == 0)
            qlen = $urandom_range(p.len - 1);
        end else begin
          qlen = p.len;
          if (p.len == KW && $urandom_range(1))
            qlen = $urandom_range(KW, 63);
          if ($urandom_range(4) == 0)
            qlen = $urandom_range(63);
        end
        m    = top_mask(p.len);
        bits = (p.bits & m) | ($urandom() & ~m);
        if (p.len > 0 && $urandom_range(7) == 0)
          bits ^= 32'h1 << (KW - $urandom_range(1, p.len));
        add_req(ACT_SEARCH, bits, qlen[5:0], 1'($urandom_range(1)),
                (i == 200) || (i == 900));
      end else begin
        add_req(ACT_SEARCH, $urandom(), 6'($urandom_range(63)), 1'($urandom_range(1)),
                (i == 200) || (i == 900));
      end
    end
    n_total = req_q.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (n_taken < n_total || n_seen < n_total) @(posedge clk);
    repeat (SETTLE) @(posedge clk);   // catch any stray result
    if (n_errors == 0 && verdict_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // driver: request side, changes on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    bit quiet;
    quiet = (n_taken >= 700 && n_taken < 1000);   // no random gaps in this stretch
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_acc) begin
      // offered item not taken yet: hold it
    end else if (req_q.size() > 0 && !(req_q[0].drain && verdict_q.size() != 0) &&
                 (quiet || $urandom_range(99) >= 31)) begin
      in_ch.action       <= req_q[0].action;
      in_ch.key_bits     <= req_q[0].key_bits;
      in_ch.key_length   <= req_q[0].key_length;
      in_ch.wildcard_req <= req_q[0].wildcard_req;
      in_ch.valid        <= 1'b1;
      void'(req_q.pop_front());
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // result side back-pressure, same edge
  always @(negedge clk) begin
    if (!rst_n)
      out_ch.ready <= 1'b0;
    else
      out_ch.ready <= (n_seen >= 700 && n_seen < 1000) || ($urandom_range(99) >= 31);
  end

  // ---------------------------------------------------------------------------
  // monitor: samples both channels on the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    request_t seen;
    verdict_t want;
    bit       in_fire;
    bit       out_fire;
    if (!rst_n) begin
      in_acc <= 1'b0;
    end else begin
      in_fire  = in_ch.valid && in_ch.ready;
      out_fire = out_ch.valid && out_ch.ready;
      in_acc  <= in_fire;
      if (in_fire) begin
        seen.action       = in_ch.action;
        seen.key_bits     = in_ch.key_bits;
        seen.key_length   = in_ch.key_length;
        seen.wildcard_req = in_ch.wildcard_req;
        seen.drain        = 1'b0;
        verdict_q = {verdict_q, predict_verdict(seen)};
        n_taken++;
      end
      if (out_fire) begin
        n_seen++;
        if (verdict_q.size() == 0) begin
          $error("result item with no outstanding request");
          n_errors++;
        end else begin
          want = verdict_q.pop_front();
          if (out_ch.matched !== want.matched) begin
            $error("matched: expected %0b, got %0b", want.matched, out_ch.matched);
            n_errors++;
          end
          if (out_ch.table_full !== want.table_full) begin
            $error("table_full: expected %0b, got %0b", want.table_full,
                   out_ch.table_full);
            n_errors++;
          end
        end
      end
      // watchdog: even a search over a full table ends well within this limit
      if (in_fire || out_fire) begin
        idle_cnt = 0;
      end else begin
        idle_cnt++;
        if (idle_cnt >= STALL_LIMIT) begin
          $display("end of test: mismatches");
          $finish;
        end
      end
    end
  end

endmodule
